[hdl/arpr_pkg.sv]
// Shared types and constants for the ARP responder/resolver.
// Command and result codes, header constants, register indexes and structs.
// No dependencies.
`default_nettype none

package arpr_pkg;

	// command codes
	localparam logic [1:0] CMD_PACKET  = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_RESOLVE = 2'd2;

	// result kinds
	localparam logic [1:0] RES_REPLY    = 2'd0;
	localparam logic [1:0] RES_REQUEST  = 2'd1;
	localparam logic [1:0] RES_RESOLVED = 2'd2;
	localparam logic [1:0] RES_FAILED   = 2'd3;

	// header constants
	localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
	localparam logic [15:0] PROTO_IPV4   = 16'h0800;
	localparam logic [15:0] HW_ETHER     = 16'h0001;
	localparam logic [15:0] OP_REQ       = 16'h0001;
	localparam logic [15:0] OP_REP       = 16'h0002;
	localparam logic [1:0]  FRAME_OP_REQ = 2'd1;
	localparam logic [1:0]  FRAME_OP_REP = 2'd2;
	localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

	// register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TICKS = 3'd5;

	localparam logic [15:0] RETRY_RESET = 16'd500;
	localparam logic [15:0] TOTAL_RESET = 16'd2000;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [47:0] local_mac;
		logic [31:0] net_mask;
		logic [31:0] gateway_ip;
		logic [15:0] retry_ticks;
		logic [15:0] total_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] frame_type;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [15:0] op_code;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [31:0] query_ip;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] dest_mac;
		logic [1:0]  opcode;
		logic [31:0] target_ip;
		logic [47:0] target_mac;
		logic [47:0] found_mac;
	} result_t;

endpackage

`default_nettype wire

[hdl/arpr_cfg_regs.sv]
// Configuration register file for the ARP responder/resolver.
// Decodes register index writes into the cfg_t struct; uses arpr_pkg.
`default_nettype none

module arpr_cfg_regs
	import arpr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [47:0]          wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_ip    <= '0;
			cfg_q.local_mac   <= '0;
			cfg_q.net_mask    <= '0;
			cfg_q.gateway_ip  <= '0;
			cfg_q.retry_ticks <= RETRY_RESET;
			cfg_q.total_ticks <= TOTAL_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_LOCAL_IP:    cfg_q.local_ip    <= wr_data[31:0];
				CFG_LOCAL_MAC:   cfg_q.local_mac   <= wr_data;
				CFG_NET_MASK:    cfg_q.net_mask    <= wr_data[31:0];
				CFG_GATEWAY_IP:  cfg_q.gateway_ip  <= wr_data[31:0];
				CFG_RETRY_TICKS: cfg_q.retry_ticks <= wr_data[15:0];
				CFG_TOTAL_TICKS: cfg_q.total_ticks <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hdl/arp_responder_resolver.sv]
// ARP responder/resolver top level: input stage, decision logic, result register.
// Uses arpr_pkg and arpr_cfg_regs.
//
// Usage:
//  - in_* channel: one word per command (received packet, tick, resolve).
//  - out_* channel: at most one result word per command (reply frame,
//    request frame, resolved MAC, or failure).
//  - cfg_* channel: register writes, always ready; write only while idle.
//  - An accepted word is registered in the input stage; as it leaves that
//    stage its result, if it makes one, is loaded into the output register,
//    which drives out_valid until the result is taken.
//  - Throughput is one word per cycle while the input stage hands its word
//    on, which it does whenever the output register is empty, is being
//    drained, or the word makes no result.
//  - When the receiver stalls, the output register holds its word; words with
//    no result still pass, and the first one with a result waits in the input
//    stage, so in_ready drops until out_ready returns.
//  - Reset clears the handshake state, the resolver state and the
//    registers, but sets retry to 500 ticks and total to 2000 ticks.
//  - Resolver state (pending address, window and elapsed counters) is
//    updated as the word leaves the input stage.
`default_nettype none

module arp_responder_resolver
	import arpr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [47:0]          cfg_data,
	// command words
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [1:0]           cmd,
	input  wire logic [15:0]          frame_type,
	input  wire logic [15:0]          hw_type,
	input  wire logic [15:0]          proto_type,
	input  wire logic [15:0]          op_code,
	input  wire logic [47:0]          sender_mac,
	input  wire logic [31:0]          sender_ip,
	input  wire logic [31:0]          target_ip,
	input  wire logic [31:0]          query_ip,
	// result words
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic [1:0]           result_kind,
	output      logic [47:0]          frame_dest_mac,
	output      logic [1:0]           frame_opcode,
	output      logic [31:0]          frame_target_ip,
	output      logic [47:0]          frame_target_mac,
	output      logic [47:0]          found_mac
);

	cfg_t cfg;

	assign cfg_ready = 1'b1;

	arpr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input stage
	logic    valid_s1;
	item_t   item_s1;

	// resolver state
	logic        resolving_q;
	logic [31:0] pending_ip_q;
	logic [15:0] window_q;
	logic [15:0] elapsed_q;

	// output register
	logic    out_valid_q;
	result_t res_q;

	// decision logic
	logic        has_res;
	result_t     res;
	logic        resolving_d;
	logic [31:0] pending_ip_d;
	logic [15:0] window_d;
	logic [15:0] elapsed_d;
	logic [15:0] window_inc;
	logic [15:0] elapsed_inc;
	logic        advance;

	always_comb begin
		has_res      = 1'b0;
		res          = '0;
		resolving_d  = resolving_q;
		pending_ip_d = pending_ip_q;
		window_d     = window_q;
		elapsed_d    = elapsed_q;
		window_inc   = (window_q == COUNT_MAX) ? window_q : window_q + 16'd1;
		elapsed_inc  = (elapsed_q == COUNT_MAX) ? elapsed_q : elapsed_q + 16'd1;

		case (item_s1.cmd)
			CMD_PACKET: begin
				if (resolving_q) begin
					if (item_s1.frame_type == ETH_TYPE_ARP &&
					    item_s1.proto_type == PROTO_IPV4 &&
					    item_s1.sender_ip == pending_ip_q &&
					    item_s1.op_code == OP_REP) begin
						has_res       = 1'b1;
						res.kind      = RES_RESOLVED;
						res.found_mac = item_s1.sender_mac;
						resolving_d   = 1'b0;
						window_d      = '0;
						elapsed_d     = '0;
					end
				end else if (item_s1.hw_type == HW_ETHER &&
				             item_s1.proto_type == PROTO_IPV4 &&
				             item_s1.op_code == OP_REQ &&
				             item_s1.target_ip == cfg.local_ip) begin
					has_res        = 1'b1;
					res.kind       = RES_REPLY;
					res.dest_mac   = item_s1.sender_mac;
					res.opcode     = FRAME_OP_REP;
					res.target_ip  = item_s1.sender_ip;
					res.target_mac = item_s1.sender_mac;
				end
			end
			CMD_RESOLVE: begin
				// off-subnet targets resolve through the gateway
				if ((item_s1.query_ip & cfg.net_mask) != (cfg.local_ip & cfg.net_mask))
					pending_ip_d = cfg.gateway_ip;
				else
					pending_ip_d = item_s1.query_ip;
				resolving_d   = 1'b1;
				window_d      = '0;
				elapsed_d     = '0;
				has_res       = 1'b1;
				res.kind      = RES_REQUEST;
				res.dest_mac  = MAC_BCAST;
				res.opcode    = FRAME_OP_REQ;
				res.target_ip = pending_ip_d;
			end
			CMD_TICK: begin
				if (resolving_q) begin
					elapsed_d = elapsed_inc;
					window_d  = window_inc;
					if (window_inc >= cfg.retry_ticks) begin
						window_d = '0;
						has_res  = 1'b1;
						if (elapsed_inc < cfg.total_ticks) begin
							res.kind      = RES_REQUEST;
							res.dest_mac  = MAC_BCAST;
							res.opcode    = FRAME_OP_REQ;
							res.target_ip = pending_ip_q;
						end else begin
							res.kind    = RES_FAILED;
							resolving_d = 1'b0;
							elapsed_d   = '0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// a word with no result leaves the input stage even if the output is full
	assign advance  = valid_s1 && (!out_valid_q || out_ready || !has_res);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			resolving_q  <= 1'b0;
			pending_ip_q <= '0;
			window_q     <= '0;
			elapsed_q    <= '0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance) begin
				resolving_q  <= resolving_d;
				pending_ip_q <= pending_ip_d;
				window_q     <= window_d;
				elapsed_q    <= elapsed_d;
			end

			if (advance && has_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd        <= cmd;
			item_s1.frame_type <= frame_type;
			item_s1.hw_type    <= hw_type;
			item_s1.proto_type <= proto_type;
			item_s1.op_code    <= op_code;
			item_s1.sender_mac <= sender_mac;
			item_s1.sender_ip  <= sender_ip;
			item_s1.target_ip  <= target_ip;
			item_s1.query_ip   <= query_ip;
		end
		if (advance && has_res)
			res_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = res_q.kind;
	assign frame_dest_mac   = res_q.dest_mac;
	assign frame_opcode     = res_q.opcode;
	assign frame_target_ip  = res_q.target_ip;
	assign frame_target_mac = res_q.target_mac;
	assign found_mac        = res_q.found_mac;

endmodule

`default_nettype wire
